@@ src/pisp_pkg.sv @@
package pisp_pkg;

  // parse position within one instruction
  typedef enum logic [2:0] {
    PH_TYPE,
    PH_F1,
    PH_F2,
    PH_F3,
    PH_RVAL,
    PH_IDATA
  } phase_e;

  // instruction selected by the type byte
  typedef enum logic [1:0] {
    KIND_REPEAT,
    KIND_INSERT,
    KIND_COPY
  } kind_e;

  // command code on the result side
  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_FILL  = 2'd1,
    CMD_COPY  = 2'd2
  } cmd_e;

  localparam logic [7:0] TYPE_REPEAT = 8'h52;  // 'R'
  localparam logic [7:0] TYPE_INSERT = 8'h49;  // 'I'
  localparam logic [7:0] TYPE_COPY   = 8'h43;  // 'C'

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned CMD_BITS    = 2;
  localparam int unsigned OUT_BITS    = 32;

endpackage

@@ src/patch_instruction_stream_parser.sv @@
// Patch instruction stream parser: takes a decompressed patch stream one byte per word and
// turns repeat, insert and copy instructions into fill, byte-write and copy commands for a
// target buffer of target_size bytes. One byte is accepted every cycle while full is low;
// type and field bytes give no word, each insert data byte gives one write word, the value
// byte of a repeat one fill word and the last byte of a copy's end field one copy word. A
// command passes from its last byte through the two-entry command queue between the parser
// and the executer and then through the result register to the result ports. The
// executer retires one command per cycle, so with pop held high the stream never stalls;
// full only rises when results are not being taken. target_size may only be written while
// no command is in flight.
module patch_instruction_stream_parser #(
  parameter int unsigned ADDR_BITS   = 32,
  parameter int unsigned FIELD_BYTES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte side
  input  logic        push,
  output logic        full,
  input  logic [7:0]  patch_byte_i,
  // command side
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  command_kind_o,
  output logic [31:0] dest_addr_o,
  output logic [31:0] src_addr_o,
  output logic [31:0] run_length_o,
  output logic [7:0]  byte_value_o,
  output logic        field_error_o,
  // configuration
  input  logic        target_size_we_i,
  input  logic [31:0] target_size_i
);

  localparam int unsigned FIELD_W = 8 * FIELD_BYTES;
  // kind, three fields, value byte, error flag
  localparam int unsigned ENTRY_W = pisp_pkg::CMD_BITS + 3 * FIELD_W + 9;

  logic                  byte_take;
  logic                  cmd_valid;
  pisp_pkg::cmd_e        cmd_kind;
  logic [FIELD_W-1:0]    cmd_a, cmd_b, cmd_c;
  logic [7:0]            cmd_value;
  logic                  cmd_err;

  logic [ENTRY_W-1:0]    q_wdata, q_rdata;
  logic                  q_full, q_valid, q_pop;

  logic [pisp_pkg::CMD_BITS-1:0] h_kind;
  logic [FIELD_W-1:0]    h_a, h_b, h_c;
  logic [7:0]            h_value;
  logic                  h_err;
  logic                  out_valid;

  // the parser only moves when the queue can take whatever this byte produces
  assign full      = q_full;
  assign byte_take = push && !q_full;

  pisp_front #(
    .ADDR_BITS  (ADDR_BITS),
    .FIELD_BYTES(FIELD_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_valid_i(byte_take),
    .byte_i      (patch_byte_i),
    .cmd_valid_o (cmd_valid),
    .cmd_kind_o  (cmd_kind),
    .cmd_a_o     (cmd_a),
    .cmd_b_o     (cmd_b),
    .cmd_c_o     (cmd_c),
    .cmd_value_o (cmd_value),
    .cmd_err_o   (cmd_err)
  );

  assign q_wdata = {pisp_pkg::CMD_BITS'(cmd_kind), cmd_a, cmd_b, cmd_c, cmd_value, cmd_err};

  // decouples parsing from command execution
  pisp_queue #(
    .WIDTH(ENTRY_W),
    .DEPTH(pisp_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (cmd_valid),
    .wr_data_i(q_wdata),
    .full_o   (q_full),
    .rd_en_i  (q_pop),
    .rd_data_o(q_rdata),
    .valid_o  (q_valid)
  );

  assign {h_kind, h_a, h_b, h_c, h_value, h_err} = q_rdata;

  // fill clamping, copy length and end-before-begin check, then the result register
  pisp_back #(
    .FIELD_BYTES(FIELD_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ts_we_i     (target_size_we_i),
    .ts_i        (target_size_i),
    .head_valid_i(q_valid),
    .head_pop_o  (q_pop),
    .head_kind_i (pisp_pkg::cmd_e'(h_kind)),
    .head_a_i    (h_a),
    .head_b_i    (h_b),
    .head_c_i    (h_c),
    .head_value_i(h_value),
    .head_err_i  (h_err),
    .out_valid_o (out_valid),
    .out_pop_i   (pop),
    .out_kind_o  (command_kind_o),
    .out_dest_o  (dest_addr_o),
    .out_src_o   (src_addr_o),
    .out_len_o   (run_length_o),
    .out_value_o (byte_value_o),
    .out_err_o   (field_error_o)
  );

  assign empty = !out_valid;

endmodule

@@ src/pisp_queue.sv @@
module pisp_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [WIDTH-1:0] wr_data_i,
  output logic             full_o,
  input  logic             rd_en_i,
  output logic [WIDTH-1:0] rd_data_o,
  output logic             valid_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_wr, do_rd;

  assign full_o    = (count_q == CNT_W'(DEPTH));
  assign valid_o   = (count_q != '0);
  assign rd_data_o = mem_q[rd_ptr_q];
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_d = count_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

@@ src/pisp_front.sv @@
module pisp_front #(
  parameter int unsigned ADDR_BITS   = 32,
  parameter int unsigned FIELD_BYTES = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           byte_valid_i,
  input  logic [7:0]                     byte_i,
  output logic                           cmd_valid_o,
  output pisp_pkg::cmd_e                 cmd_kind_o,
  output logic [8*FIELD_BYTES-1:0]       cmd_a_o,
  output logic [8*FIELD_BYTES-1:0]       cmd_b_o,
  output logic [8*FIELD_BYTES-1:0]       cmd_c_o,
  output logic [7:0]                     cmd_value_o,
  output logic                           cmd_err_o
);

  localparam int unsigned FIELD_W = 8 * FIELD_BYTES;
  localparam int unsigned CNT_W   = $clog2(FIELD_BYTES);

  pisp_pkg::phase_e     phase_q, phase_d;
  pisp_pkg::kind_e      kind_q, kind_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [FIELD_W-1:0]   shift_q, shift_d;
  logic [FIELD_W-1:0]   first_q, first_d;
  logic [FIELD_W-1:0]   second_q, second_d;
  logic [FIELD_W-1:0]   remain_q, remain_d;
  logic [ADDR_BITS-1:0] iaddr_q, iaddr_d;

  logic [FIELD_W-1:0]   field_v;
  logic                 last_byte;
  logic                 fits_first, fits_second, fits_v;

  assign field_v     = shift_q | (FIELD_W'(byte_i) << {cnt_q, 3'b000});
  assign last_byte   = (cnt_q == CNT_W'(FIELD_BYTES - 1));
  assign fits_first  = ((first_q >> ADDR_BITS) == '0);
  assign fits_second = ((second_q >> ADDR_BITS) == '0);
  assign fits_v      = ((field_v >> ADDR_BITS) == '0);

  // next state and field collection
  always_comb begin
    phase_d  = phase_q;
    kind_d   = kind_q;
    cnt_d    = cnt_q;
    shift_d  = shift_q;
    first_d  = first_q;
    second_d = second_q;
    remain_d = remain_q;
    iaddr_d  = iaddr_q;
    if (byte_valid_i) begin
      unique case (phase_q)
        pisp_pkg::PH_TYPE: begin
          cnt_d   = '0;
          shift_d = '0;
          priority if (byte_i == pisp_pkg::TYPE_REPEAT) begin
            kind_d  = pisp_pkg::KIND_REPEAT;
            phase_d = pisp_pkg::PH_F1;
          end else if (byte_i == pisp_pkg::TYPE_INSERT) begin
            kind_d  = pisp_pkg::KIND_INSERT;
            phase_d = pisp_pkg::PH_F1;
          end else if (byte_i == pisp_pkg::TYPE_COPY) begin
            kind_d  = pisp_pkg::KIND_COPY;
            phase_d = pisp_pkg::PH_F1;
          end else begin
            cnt_d   = cnt_q;
            shift_d = shift_q;
          end
        end
        pisp_pkg::PH_F1, pisp_pkg::PH_F2, pisp_pkg::PH_F3: begin
          if (!last_byte) begin
            shift_d = field_v;
            cnt_d   = cnt_q + 1'b1;
          end else begin
            shift_d = '0;
            cnt_d   = '0;
            unique case (phase_q)
              pisp_pkg::PH_F1: begin
                first_d = field_v;
                phase_d = pisp_pkg::PH_F2;
              end
              pisp_pkg::PH_F2: begin
                second_d = field_v;
                unique case (kind_q)
                  pisp_pkg::KIND_REPEAT: phase_d = pisp_pkg::PH_RVAL;
                  pisp_pkg::KIND_INSERT: begin
                    remain_d = field_v;
                    iaddr_d  = ADDR_BITS'(first_q);
                    phase_d  = (field_v != '0) ? pisp_pkg::PH_IDATA : pisp_pkg::PH_TYPE;
                  end
                  pisp_pkg::KIND_COPY:   phase_d = pisp_pkg::PH_F3;
                  default:               phase_d = pisp_pkg::PH_TYPE;
                endcase
              end
              default: phase_d = pisp_pkg::PH_TYPE;
            endcase
          end
        end
        pisp_pkg::PH_RVAL: phase_d = pisp_pkg::PH_TYPE;
        pisp_pkg::PH_IDATA: begin
          iaddr_d = iaddr_q + 1'b1;
          if (remain_q != '0) begin
            remain_d = remain_q - 1'b1;
          end
          if (remain_q <= FIELD_W'(1)) begin
            phase_d = pisp_pkg::PH_TYPE;
          end
        end
        default: phase_d = pisp_pkg::PH_TYPE;
      endcase
    end
  end

  // command word towards the queue
  always_comb begin
    cmd_valid_o = 1'b0;
    cmd_kind_o  = pisp_pkg::CMD_WRITE;
    cmd_a_o     = first_q;
    cmd_b_o     = second_q;
    cmd_c_o     = field_v;
    cmd_value_o = byte_i;
    cmd_err_o   = !fits_first || !fits_second;
    unique case (phase_q)
      pisp_pkg::PH_F3: begin
        cmd_valid_o = byte_valid_i && last_byte;
        cmd_kind_o  = pisp_pkg::CMD_COPY;
        cmd_err_o   = !fits_first || !fits_second || !fits_v;
      end
      pisp_pkg::PH_RVAL: begin
        cmd_valid_o = byte_valid_i;
        cmd_kind_o  = pisp_pkg::CMD_FILL;
      end
      pisp_pkg::PH_IDATA: begin
        cmd_valid_o = byte_valid_i;
        cmd_kind_o  = pisp_pkg::CMD_WRITE;
        cmd_a_o     = FIELD_W'(iaddr_q);
      end
      default: cmd_valid_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= pisp_pkg::PH_TYPE;
      kind_q   <= pisp_pkg::KIND_REPEAT;
      cnt_q    <= '0;
      shift_q  <= '0;
      first_q  <= '0;
      second_q <= '0;
      remain_q <= '0;
      iaddr_q  <= '0;
    end else begin
      phase_q  <= phase_d;
      kind_q   <= kind_d;
      cnt_q    <= cnt_d;
      shift_q  <= shift_d;
      first_q  <= first_d;
      second_q <= second_d;
      remain_q <= remain_d;
      iaddr_q  <= iaddr_d;
    end
  end

endmodule

@@ src/pisp_back.sv @@
module pisp_back #(
  parameter int unsigned FIELD_BYTES = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     ts_we_i,
  input  logic [31:0]              ts_i,
  input  logic                     head_valid_i,
  output logic                     head_pop_o,
  input  pisp_pkg::cmd_e           head_kind_i,
  input  logic [8*FIELD_BYTES-1:0] head_a_i,
  input  logic [8*FIELD_BYTES-1:0] head_b_i,
  input  logic [8*FIELD_BYTES-1:0] head_c_i,
  input  logic [7:0]               head_value_i,
  input  logic                     head_err_i,
  output logic                     out_valid_o,
  input  logic                     out_pop_i,
  output logic [1:0]               out_kind_o,
  output logic [31:0]              out_dest_o,
  output logic [31:0]              out_src_o,
  output logic [31:0]              out_len_o,
  output logic [7:0]               out_value_o,
  output logic                     out_err_o
);

  localparam int unsigned FIELD_W = 8 * FIELD_BYTES;

  logic [31:0]        ts_q;
  logic               valid_q;
  logic [1:0]         kind_q, kind_d;
  logic [31:0]        dest_q, dest_d;
  logic [31:0]        src_q, src_d;
  logic [31:0]        len_q, len_d;
  logic [7:0]         value_q, value_d;
  logic               err_q, err_d;

  logic [FIELD_W-1:0] ts_ext, room, fill_len, copy_len;
  logic               past_end, copy_back;
  logic               advance;

  assign advance    = !valid_q || out_pop_i;
  assign head_pop_o = advance && head_valid_i;

  // fill clamp and copy span
  assign ts_ext    = FIELD_W'(ts_q);
  assign past_end  = (head_a_i >= ts_ext);
  assign room      = ts_ext - head_a_i;
  assign fill_len  = past_end ? '0 : ((head_b_i < room) ? head_b_i : room);
  assign copy_back = (head_c_i < head_b_i);
  assign copy_len  = copy_back ? '0 : (head_c_i - head_b_i);

  always_comb begin
    kind_d  = pisp_pkg::CMD_BITS'(head_kind_i);
    dest_d  = 32'(head_a_i);
    src_d   = '0;
    len_d   = 32'd1;
    value_d = head_value_i;
    err_d   = head_err_i;
    unique case (head_kind_i)
      pisp_pkg::CMD_FILL: len_d = 32'(fill_len);
      pisp_pkg::CMD_COPY: begin
        src_d   = 32'(head_b_i);
        len_d   = 32'(copy_len);
        value_d = '0;
        err_d   = head_err_i || copy_back;
      end
      default: len_d = 32'd1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ts_q    <= '0;
      valid_q <= 1'b0;
    end else begin
      if (ts_we_i) begin
        ts_q <= ts_i;
      end
      if (advance) begin
        valid_q <= head_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (head_pop_o) begin
      kind_q  <= kind_d;
      dest_q  <= dest_d;
      src_q   <= src_d;
      len_q   <= len_d;
      value_q <= value_d;
      err_q   <= err_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_kind_o  = kind_q;
  assign out_dest_o  = dest_q;
  assign out_src_o   = src_q;
  assign out_len_o   = len_q;
  assign out_value_o = value_q;
  assign out_err_o   = err_q;

endmodule
